[rtl/core/ffpa_pkg.sv]
// shared constants and result codes of the first-fit page allocator
package ffpa_pkg;

  localparam int NUM_PAGES_DEF = 1024;
  localparam int PAGE_COUNT_W  = 11;
  localparam int PAGE_INDEX_W  = 10;
  localparam int STATUS_W      = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_START    = 2'd3;

endpackage

[rtl/core/ffpa_ram.sv]
// generic single-port ram with registered read
module ffpa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/first_fit_page_allocator_core.sv]
// first-fit page allocator: max-tree of free runs in one ram, walked by a sequencer
//
// The pool of NUM_PAGES pages (a power of two) is kept as a max-tree of 2*NUM_PAGES
// nodes in a single-port ram; node 1 is the root and the leaf of page p is node
// NUM_PAGES+p. After reset a clearing pass initializes the ram, and in_ready stays
// low until it ends. One transaction is worked on at a time over the one ram port,
// so the time it takes follows the number of ram accesses: an allocate walks down
// the tree, marks the granted leaves and updates the path to the root, and updates
// a second path when the granted run is split; a free releases the run's leaves,
// scans left page by page to the start of the preceding run and updates the paths.
// Rejected requests end without writing the tree.
module first_fit_page_allocator_core
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic [PAGE_COUNT_W-1:0] in_page_count,
  input  logic [PAGE_INDEX_W-1:0] in_page_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [PAGE_INDEX_W-1:0] out_start_page
);

  localparam int PG_W   = $clog2(NUM_PAGES);
  localparam int NODE_W = PG_W + 1;
  localparam int LEN_W  = PG_W + 1;
  localparam int DW     = LEN_W + 1;
  localparam int XW     = (PG_W + 2 > 12) ? PG_W + 2 : 12;
  localparam int DEPTH  = 2 * NUM_PAGES;

  localparam logic [XW-1:0]     NP_X    = XW'(NUM_PAGES);
  localparam logic [NODE_W-1:0] ROOT    = NODE_W'(1);

  typedef enum logic [15:0] {
    S_CLR     = 16'h0001,
    S_IDLE    = 16'h0002,
    S_A_CHK   = 16'h0004,
    S_A_DRD   = 16'h0008,
    S_A_DCMP  = 16'h0010,
    S_A_LEAF  = 16'h0020,
    S_A_MARK  = 16'h0040,
    S_F_LEAF  = 16'h0080,
    S_F_REL   = 16'h0100,
    S_F_RGT   = 16'h0200,
    S_F_LFT0  = 16'h0400,
    S_F_LCHK  = 16'h0800,
    S_SL_WR   = 16'h1000,
    S_SL_RD   = 16'h2000,
    S_SL_UP   = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  function automatic logic [LEN_W-1:0] free_len(input logic [DW-1:0] v);
    free_len = v[DW-1] ? '0 : v[LEN_W-1:0];
  endfunction

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] sl_node_r, sl_node_nxt;
  logic [LEN_W-1:0]  sl_len_r, sl_len_nxt;
  logic              sl_alloc_r, sl_alloc_nxt;
  logic [NODE_W-1:0] walk_r, walk_nxt;
  logic [LEN_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  avail_r, avail_nxt;
  logic [XW-1:0]     cnt_r, cnt_nxt;
  logic [XW-1:0]     i_r, i_nxt;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [PG_W-1:0]   j_r, j_nxt;
  logic              first_r, first_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [PAGE_INDEX_W-1:0] res_start_r, res_start_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [PAGE_INDEX_W-1:0] out_start_r, out_start_nxt;

  logic              ram_we;
  logic [NODE_W-1:0] ram_addr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  logic [XW-1:0]     lo_x, page_x, in_page_x, rd_len_x, node_x;
  logic [LEN_W-1:0]  rd_free, up_max;

  ffpa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign lo_x      = XW'(node_r[PG_W-1:0]);
  assign page_x    = XW'(page_r);
  assign in_page_x = XW'(in_page_index);
  assign rd_len_x  = XW'(ram_rdata[LEN_W-1:0]);
  assign node_x    = XW'(node_r);
  assign rd_free   = free_len(ram_rdata);
  assign up_max    = (cur_r > rd_free) ? cur_r : rd_free;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_page = out_start_r;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    sl_node_nxt    = sl_node_r;
    sl_len_nxt     = sl_len_r;
    sl_alloc_nxt   = sl_alloc_r;
    walk_nxt       = walk_r;
    cur_nxt        = cur_r;
    avail_nxt      = avail_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    page_nxt       = page_r;
    j_nxt          = j_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    ram_we         = 1'b0;
    ram_addr       = node_r;
    ram_wdata      = '0;

    unique case (state_r)
      S_CLR: begin
        // root path of page zero starts as one free run of the whole pool
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = ((clr_r & (clr_r - NODE_W'(1))) == '0 && clr_r != '0) ?
                    {1'b0, LEN_W'(NUM_PAGES)} : '0;
        clr_nxt   = clr_r + NODE_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_start_nxt = '0;
        cnt_nxt       = XW'(in_page_count);
        if (in_valid) begin
          if (in_opcode == OP_ALLOC) begin
            ram_addr  = ROOT;
            state_nxt = S_A_CHK;
          end else if (in_page_x >= NP_X) begin
            res_status_nxt = ST_NOT_START;
            state_nxt      = S_DONE;
          end else begin
            ram_addr  = NODE_W'(NP_X + in_page_x);
            node_nxt  = NODE_W'(NP_X + in_page_x);
            page_nxt  = PG_W'(in_page_index);
            state_nxt = S_F_LEAF;
          end
        end
      end
      S_A_CHK: begin
        if (cnt_r == '0 || rd_len_x < cnt_r) begin
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          node_nxt  = ROOT;
          state_nxt = S_A_DRD;
        end
      end
      S_A_DRD: begin
        if (node_r[PG_W]) begin
          ram_addr  = node_r;
          state_nxt = S_A_LEAF;
        end else begin
          ram_addr  = {node_r[NODE_W-2:0], 1'b0};
          state_nxt = S_A_DCMP;
        end
      end
      S_A_DCMP: begin
        node_nxt  = {node_r[NODE_W-2:0], !(XW'(rd_free) >= cnt_r)};
        state_nxt = S_A_DRD;
      end
      S_A_LEAF: begin
        avail_nxt    = rd_free;
        i_nxt        = XW'(1);
        sl_node_nxt  = node_r;
        sl_len_nxt   = LEN_W'(cnt_r);
        sl_alloc_nxt = 1'b1;
        ret_nxt      = S_A_MARK;
        state_nxt    = S_SL_WR;
      end
      S_A_MARK: begin
        if (i_r < cnt_r && lo_x + i_r < NP_X) begin
          ram_we    = 1'b1;
          ram_addr  = NODE_W'(node_x + i_r);
          ram_wdata = {1'b1, LEN_W'(0)};
          i_nxt     = i_r + XW'(1);
        end else begin
          res_status_nxt = ST_DONE;
          res_start_nxt  = lo_x[PAGE_INDEX_W-1:0];
          if (XW'(avail_r) > cnt_r && lo_x + cnt_r < NP_X) begin
            // split off the rest of the run as a new free run
            sl_node_nxt  = NODE_W'(node_x + cnt_r);
            sl_len_nxt   = LEN_W'(XW'(avail_r) - cnt_r);
            sl_alloc_nxt = 1'b0;
            ret_nxt      = S_DONE;
            state_nxt    = S_SL_WR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_F_LEAF: begin
        i_nxt = '0;
        if (!ram_rdata[DW-1]) begin
          res_status_nxt = ST_ALREADY_FREE;
          state_nxt      = S_DONE;
        end else if (ram_rdata[LEN_W-1:0] == '0) begin
          res_status_nxt = ST_NOT_START;
          state_nxt      = S_DONE;
        end else begin
          res_status_nxt = ST_DONE;
          cnt_nxt   = (rd_len_x > NP_X - page_x) ? NP_X - page_x : rd_len_x;
          state_nxt = S_F_REL;
        end
      end
      S_F_REL: begin
        if (i_r < cnt_r) begin
          ram_we    = 1'b1;
          ram_addr  = NODE_W'(node_x + i_r);
          ram_wdata = '0;
          i_nxt     = i_r + XW'(1);
        end else if (page_x + cnt_r < NP_X) begin
          ram_addr  = NODE_W'(node_x + cnt_r);
          state_nxt = S_F_RGT;
        end else begin
          state_nxt = S_F_LFT0;
        end
      end
      S_F_RGT: begin
        if (!ram_rdata[DW-1]) begin
          // absorb the free run that follows
          cnt_nxt      = cnt_r + rd_len_x;
          sl_node_nxt  = NODE_W'(node_x + cnt_r);
          sl_len_nxt   = '0;
          sl_alloc_nxt = 1'b0;
          ret_nxt      = S_F_LFT0;
          state_nxt    = S_SL_WR;
        end else begin
          state_nxt = S_F_LFT0;
        end
      end
      S_F_LFT0: begin
        if (page_r == '0) begin
          sl_node_nxt  = node_r;
          sl_len_nxt   = LEN_W'(cnt_r);
          sl_alloc_nxt = 1'b0;
          ret_nxt      = S_DONE;
          state_nxt    = S_SL_WR;
        end else begin
          j_nxt     = page_r;
          first_nxt = 1'b1;
          ram_addr  = node_r - NODE_W'(1);
          state_nxt = S_F_LCHK;
        end
      end
      S_F_LCHK: begin
        first_nxt    = 1'b0;
        sl_alloc_nxt = 1'b0;
        ret_nxt      = S_DONE;
        sl_node_nxt  = node_r;
        sl_len_nxt   = LEN_W'(cnt_r);
        if (first_r && ram_rdata[DW-1]) begin
          state_nxt = S_SL_WR;
        end else if (ram_rdata[LEN_W-1:0] == '0) begin
          // walk left until a run start turns up
          if (j_r == PG_W'(1)) begin
            state_nxt = S_SL_WR;
          end else begin
            j_nxt    = j_r - PG_W'(1);
            ram_addr = NODE_W'(NP_X + XW'(j_r) - XW'(2));
          end
        end else begin
          sl_node_nxt = NODE_W'(NP_X + XW'(j_r) - XW'(1));
          sl_len_nxt  = LEN_W'(XW'(rd_free) + cnt_r);
          state_nxt   = S_SL_WR;
        end
      end
      S_SL_WR: begin
        ram_we    = 1'b1;
        ram_addr  = sl_node_r;
        ram_wdata = {sl_alloc_r, sl_len_r};
        cur_nxt   = sl_alloc_r ? '0 : sl_len_r;
        walk_nxt  = sl_node_r;
        state_nxt = S_SL_RD;
      end
      S_SL_RD: begin
        if (walk_r == ROOT) begin
          state_nxt = ret_r;
        end else begin
          ram_addr  = walk_r ^ NODE_W'(1);
          state_nxt = S_SL_UP;
        end
      end
      S_SL_UP: begin
        ram_we    = 1'b1;
        ram_addr  = walk_r >> 1;
        ram_wdata = {1'b0, up_max};
        cur_nxt   = up_max;
        walk_nxt  = walk_r >> 1;
        state_nxt = S_SL_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_DONE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    sl_node_r    <= sl_node_nxt;
    sl_len_r     <= sl_len_nxt;
    sl_alloc_r   <= sl_alloc_nxt;
    walk_r       <= walk_nxt;
    cur_r        <= cur_nxt;
    avail_r      <= avail_nxt;
    cnt_r        <= cnt_nxt;
    i_r          <= i_nxt;
    page_r       <= page_nxt;
    j_r          <= j_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

`ifndef ASSERT_OFF
  a_start_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_DONE |-> out_start_r == '0)
    else $error("nonzero start page on a failed transaction");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_DONE |-> !ram_we)
    else $error("tree written while no transaction is in progress");

  a_walk_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SL_UP |-> walk_r != ROOT && walk_r != '0)
    else $error("path update stepped above the root");
`endif

endmodule
